// File: hdl/pidc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types and constants of the positional / incremental PID core.
// ----------------------------------------------------------------------------
package pidc_pkg;

   // Gains are signed Q-format words of fixed width
   localparam int GAIN_WIDTH = 16;
   // Drive is always saturated to this width
   localparam int OUT_WIDTH  = 32;

   // Control register map
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SETPOINT    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_P      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_I      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_D      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FORM_SELECT = 3'd4;

   // Output form codes
   localparam logic FORM_INCREMENTAL = 1'b0;
   localparam logic FORM_POSITIONAL  = 1'b1;

   // Per-stage control carried alongside the datapath
   typedef struct packed {
      logic valid;
      logic sat;
   } stage_ctl_type;

endpackage

// File: hdl/pidc_error.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_error
// Error stage: forms the error, updates error history and the saturating
// error sum, and selects the operands of the three multipliers.
// ----------------------------------------------------------------------------
module pidc_error #(
   parameter int DATA_WIDTH = 16,
   parameter int SUM_WIDTH  = 32,
   parameter int OPI_WIDTH  = 33
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  pidc_pkg::stage_ctl_type       ctl_in,
   input  logic signed [DATA_WIDTH-1:0]  meas,
   input  logic signed [DATA_WIDTH-1:0]  setpoint,
   input  logic                          form_select,
   output pidc_pkg::stage_ctl_type       ctl_ff,
   output logic signed [DATA_WIDTH:0]    op_p_ff,
   output logic signed [OPI_WIDTH-1:0]   op_i_ff,
   output logic signed [DATA_WIDTH+1:0]  op_d_ff
);
   import pidc_pkg::*;

   localparam int XW = ((SUM_WIDTH > DATA_WIDTH + 1) ? SUM_WIDTH : DATA_WIDTH + 1) + 1;
   localparam logic signed [XW-1:0] SUM_HI = {{(XW-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [XW-1:0] SUM_LO = {{(XW-SUM_WIDTH+1){1'b1}}, {(SUM_WIDTH-1){1'b0}}};

   logic signed [DATA_WIDTH:0]   err_last_ff, err_last_in;
   logic signed [DATA_WIDTH:0]   err_prev_ff, err_prev_in;
   logic signed [SUM_WIDTH-1:0]  sum_ff, sum_in;
   logic signed [DATA_WIDTH:0]   err;
   logic signed [DATA_WIDTH+1:0] err_diff;
   logic signed [XW-1:0]         sum_wide;
   logic signed [SUM_WIDTH-1:0]  sum_clip;
   logic                         sum_hit;
   logic                         positional;
   pidc_pkg::stage_ctl_type      ctl_in_next;
   logic signed [OPI_WIDTH-1:0]  op_i_in;
   logic signed [DATA_WIDTH+1:0] op_d_in;

   assign positional = (form_select == FORM_POSITIONAL);

   // Error and its first difference; both always fit without clipping
   assign err      = $signed({setpoint[DATA_WIDTH-1], setpoint})
                   - $signed({meas[DATA_WIDTH-1], meas});
   assign err_diff = $signed({err[DATA_WIDTH], err})
                   - $signed({err_last_ff[DATA_WIDTH], err_last_ff});

   // Saturating error sum
   assign sum_wide = $signed({{(XW-SUM_WIDTH){sum_ff[SUM_WIDTH-1]}}, sum_ff})
                   + $signed({{(XW-DATA_WIDTH-1){err[DATA_WIDTH]}}, err});
   always_comb begin
      sum_hit  = 1'b0;
      sum_clip = sum_wide[SUM_WIDTH-1:0];
      if (sum_wide > SUM_HI) begin
         sum_hit  = 1'b1;
         sum_clip = SUM_HI[SUM_WIDTH-1:0];
      end else if (sum_wide < SUM_LO) begin
         sum_hit  = 1'b1;
         sum_clip = SUM_LO[SUM_WIDTH-1:0];
      end
   end

   // History update and multiplier operand select
   always_comb begin
      err_last_in = err_last_ff;
      err_prev_in = err_prev_ff;
      sum_in      = sum_ff;
      ctl_in_next = ctl_in;
      if (positional) begin
         op_i_in = $signed({{(OPI_WIDTH-SUM_WIDTH){sum_clip[SUM_WIDTH-1]}}, sum_clip});
         op_d_in = err_diff;
         ctl_in_next.sat = sum_hit;
      end else begin
         op_i_in = -$signed({{(OPI_WIDTH-DATA_WIDTH-1){err_last_ff[DATA_WIDTH]}},
                             err_last_ff});
         op_d_in = $signed({err_prev_ff[DATA_WIDTH], err_prev_ff});
         ctl_in_next.sat = 1'b0;
      end
      if (ctl_in.valid) begin
         err_last_in = err;
         if (positional) begin
            sum_in = sum_clip;
         end else begin
            err_prev_in = err_last_ff;
         end
      end
   end

   // Controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         err_last_ff <= '0;
         err_prev_ff <= '0;
         sum_ff      <= '0;
      end else if (advance) begin
         err_last_ff <= err_last_in;
         err_prev_ff <= err_prev_in;
         sum_ff      <= sum_in;
      end
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op_p_ff <= err;
         op_i_ff <= op_i_in;
         op_d_ff <= op_d_in;
      end
   end

endmodule

// File: hdl/pidc_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_mac
// Multiply, accumulate and output stages: three gain products, their sum,
// fraction removal with floor rounding and saturation to the drive width.
// ----------------------------------------------------------------------------
module pidc_mac #(
   parameter int DATA_WIDTH = 16,
   parameter int OPI_WIDTH  = 33,
   parameter int FRAC_BITS  = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  pidc_pkg::stage_ctl_type              ctl_in,
   input  logic signed [DATA_WIDTH:0]           op_p,
   input  logic signed [OPI_WIDTH-1:0]          op_i,
   input  logic signed [DATA_WIDTH+1:0]         op_d,
   input  logic signed [pidc_pkg::GAIN_WIDTH-1:0] gain_p,
   input  logic signed [pidc_pkg::GAIN_WIDTH-1:0] gain_i,
   input  logic signed [pidc_pkg::GAIN_WIDTH-1:0] gain_d,
   output logic                                 out_valid,
   output logic signed [pidc_pkg::OUT_WIDTH-1:0] out_drive,
   output logic                                 out_sat
);
   import pidc_pkg::*;

   localparam int PW_P = GAIN_WIDTH + DATA_WIDTH + 1;
   localparam int PW_I = GAIN_WIDTH + OPI_WIDTH;
   localparam int PW_D = GAIN_WIDTH + DATA_WIDTH + 2;
   localparam int AW   = PW_I + 2;
   localparam logic signed [AW-1:0] OUT_HI = {{(AW-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}};
   localparam logic signed [AW-1:0] OUT_LO = {{(AW-OUT_WIDTH+1){1'b1}}, {(OUT_WIDTH-1){1'b0}}};

   pidc_pkg::stage_ctl_type  mul_ctl_ff, acc_ctl_ff;
   logic signed [PW_P-1:0]   prod_p_ff;
   logic signed [PW_I-1:0]   prod_i_ff;
   logic signed [PW_D-1:0]   prod_d_ff;
   logic signed [AW-1:0]     acc_in, acc_ff;
   logic signed [AW-1:0]     acc_shift;
   logic signed [OUT_WIDTH-1:0] drive_in, drive_ff;
   logic                     hit_in, valid_ff, sat_ff;

   // Three independent products
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_p_ff <= PW_P'(gain_p) * PW_P'(op_p);
         prod_i_ff <= PW_I'(gain_i) * PW_I'(op_i);
         prod_d_ff <= PW_D'(gain_d) * PW_D'(op_d);
      end
   end

   // Sum of products
   assign acc_in = $signed({{(AW-PW_P){prod_p_ff[PW_P-1]}}, prod_p_ff})
                 + $signed({{(AW-PW_I){prod_i_ff[PW_I-1]}}, prod_i_ff})
                 + $signed({{(AW-PW_D){prod_d_ff[PW_D-1]}}, prod_d_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff <= acc_in;
      end
   end

   // Drop fraction bits (floor) and saturate
   assign acc_shift = acc_ff >>> FRAC_BITS;
   always_comb begin
      hit_in   = 1'b0;
      drive_in = acc_shift[OUT_WIDTH-1:0];
      if (acc_shift > OUT_HI) begin
         hit_in   = 1'b1;
         drive_in = OUT_HI[OUT_WIDTH-1:0];
      end else if (acc_shift < OUT_LO) begin
         hit_in   = 1'b1;
         drive_in = OUT_LO[OUT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         drive_ff <= drive_in;
         sat_ff   <= hit_in | acc_ctl_ff.sat;
      end
   end

   // Stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ctl_ff <= '0;
         acc_ctl_ff <= '0;
         valid_ff   <= 1'b0;
      end else if (advance) begin
         mul_ctl_ff <= ctl_in;
         acc_ctl_ff <= mul_ctl_ff;
         valid_ff   <= acc_ctl_ff.valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_drive = drive_ff;
   assign out_sat   = sat_ff;

endmodule

// File: hdl/pid_controller_inc_pos_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_inc_pos_core
// PID controller with positional or incremental output form, Q8.8 gains.
// ----------------------------------------------------------------------------
// Takes one measurement per item and returns one saturated drive value per
// item, in item order. A new item is accepted every clock cycle unless the
// pipeline is held; a result passes the input register, error stage,
// multiply, accumulate and output register. The only loop-carried path is
// the error stage, where the error history and saturating error sum are
// updated, so throughput is one item per cycle while not held. The whole
// pipeline holds while rsp_tvalid is high and rsp_tready is low, and
// req_tready is low in exactly those cycles. Control registers are to be
// written only while no item is in flight; the block itself does not enforce
// this. csr_ready is always high.
module pid_controller_inc_pos_core #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8,
   parameter int SUM_WIDTH  = 32
) (
   input  logic                                         clock,
   input  logic                                         reset,
   // request: [DATA_WIDTH-1:0] measurement, zero padded to bytes
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0]      req_tdata,
   // response tdata: [31:0] drive
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   output logic [pidc_pkg::OUT_WIDTH-1:0]               rsp_tdata,
   // response tuser: [0] saturated
   output logic                                         rsp_tuser,
   // control register writes
   input  logic                                         csr_valid,
   output logic                                         csr_ready,
   input  logic [pidc_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input  logic [((DATA_WIDTH > 16) ? DATA_WIDTH : 16) - 1:0] csr_data
);
   import pidc_pkg::*;

   localparam int OPI_WIDTH = ((SUM_WIDTH > DATA_WIDTH + 2) ? SUM_WIDTH : DATA_WIDTH + 2) + 1;

   logic signed [DATA_WIDTH-1:0] setpoint_ff;
   logic signed [GAIN_WIDTH-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic                         form_ff;
   logic signed [DATA_WIDTH-1:0] meas_ff;
   pidc_pkg::stage_ctl_type      in_ctl_ff, err_ctl;
   logic                         advance;
   logic signed [DATA_WIDTH:0]   op_p;
   logic signed [OPI_WIDTH-1:0]  op_i;
   logic signed [DATA_WIDTH+1:0] op_d;
   logic signed [OUT_WIDTH-1:0]  drive;

   // Pipeline moves whenever the output register is free or being drained
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= '0;
         gain_p_ff   <= '0;
         gain_i_ff   <= '0;
         gain_d_ff   <= '0;
         form_ff     <= FORM_POSITIONAL;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SETPOINT:    setpoint_ff <= csr_data[DATA_WIDTH-1:0];
            CSR_GAIN_P:      gain_p_ff   <= csr_data[GAIN_WIDTH-1:0];
            CSR_GAIN_I:      gain_i_ff   <= csr_data[GAIN_WIDTH-1:0];
            CSR_GAIN_D:      gain_d_ff   <= csr_data[GAIN_WIDTH-1:0];
            CSR_FORM_SELECT: form_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctl_ff <= '0;
      end else if (advance) begin
         in_ctl_ff.valid <= req_tvalid;
         in_ctl_ff.sat   <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         meas_ff <= req_tdata[DATA_WIDTH-1:0];
      end
   end

   pidc_error #(
      .DATA_WIDTH (DATA_WIDTH),
      .SUM_WIDTH  (SUM_WIDTH),
      .OPI_WIDTH  (OPI_WIDTH)
   ) u_error (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .ctl_in      (in_ctl_ff),
      .meas        (meas_ff),
      .setpoint    (setpoint_ff),
      .form_select (form_ff),
      .ctl_ff      (err_ctl),
      .op_p_ff     (op_p),
      .op_i_ff     (op_i),
      .op_d_ff     (op_d)
   );

   pidc_mac #(
      .DATA_WIDTH (DATA_WIDTH),
      .OPI_WIDTH  (OPI_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctl_in    (err_ctl),
      .op_p      (op_p),
      .op_i      (op_i),
      .op_d      (op_d),
      .gain_p    (gain_p_ff),
      .gain_i    (gain_i_ff),
      .gain_d    (gain_d_ff),
      .out_valid (rsp_tvalid),
      .out_drive (drive),
      .out_sat   (rsp_tuser)
   );

   assign rsp_tdata = drive;

endmodule

// File: hdl/pidc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_checker
// Port-level checks of the PID core's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module pidc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // Held result keeps its value until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Input side stalls exactly when the output register is blocked
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not follow output backpressure");

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A new result only shows up through a move of the pipeline, never while held
   a_rise_on_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tready))
      else $error("response appeared while pipeline was held");

endmodule

bind pid_controller_inc_pos_core pidc_checker u_pidc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/pid_drive_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_drive_checker
// Passive checker for the PID core: follows register writes, predicts every
// drive value and compares each accepted result against the oldest one.
// ----------------------------------------------------------------------------
// The checker keeps its own copy of the control registers, the error history
// and the saturating error sum. Each accepted request item produces one
// predicted result; each accepted response item is checked field by field.
// Failures go through one report task that prints a line and counts.
// ----------------------------------------------------------------------------
module pid_drive_checker #(
   parameter int DATA_WIDTH     = 16,
   parameter int FRAC_BITS      = 8,
   parameter int SUM_WIDTH      = 32,
   parameter int TDATA_WIDTH    = 16,
   parameter int CSR_DATA_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [TDATA_WIDTH-1:0]               req_tdata,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [pidc_pkg::OUT_WIDTH-1:0]       rsp_tdata,
   input  logic                                 rsp_tuser,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [pidc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]            csr_data,
   input  logic                                 run_done,
   output int                                   pending_count,
   output int                                   fail_count,
   output int                                   positional_steps,
   output int                                   incremental_steps,
   output int                                   flagged_steps,
   output int                                   drive_clips,
   output int                                   sum_top_hits,
   output int                                   sum_bottom_hits
);
   import pidc_pkg::*;

   localparam longint SUM_MAX   = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
   localparam longint SUM_MIN   = -SUM_MAX - 1;
   localparam longint DRIVE_MAX = (longint'(1) <<< (OUT_WIDTH - 1)) - 1;
   localparam longint DRIVE_MIN = -DRIVE_MAX - 1;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] drive;
      logic                 saturated;
   } drive_result_type;

   // predicted results, oldest first
   drive_result_type drive_q[$];

   // shadow control registers
   logic signed [DATA_WIDTH-1:0] setpoint_q;
   logic signed [GAIN_WIDTH-1:0] gain_p_q;
   logic signed [GAIN_WIDTH-1:0] gain_i_q;
   logic signed [GAIN_WIDTH-1:0] gain_d_q;
   logic                         form_q;

   // controller state
   longint err_last;
   longint err_prev;
   longint err_sum;

   int mismatches  = 0;
   int n_pos       = 0;
   int n_inc       = 0;
   int n_flagged   = 0;
   int n_drive_sat = 0;
   int n_sum_top   = 0;
   int n_sum_bot   = 0;
   bit leftover_checked = 1'b0;

   assign fail_count        = mismatches;
   assign positional_steps  = n_pos;
   assign incremental_steps = n_inc;
   assign flagged_steps     = n_flagged;
   assign drive_clips       = n_drive_sat;
   assign sum_top_hits      = n_sum_top;
   assign sum_bottom_hits   = n_sum_bot;

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      mismatches++;
   endtask

   // One control step: advance the state and return the expected result
   function automatic drive_result_type next_drive(input logic signed [DATA_WIDTH-1:0] meas);
      longint           err;
      longint           acc;
      longint           scaled;
      longint           sum_next;
      logic             clipped;
      drive_result_type r;
      clipped = 1'b0;
      err = longint'(setpoint_q) - longint'(meas);
      if (form_q == FORM_POSITIONAL) begin
         sum_next = err_sum + err;
         if (sum_next > SUM_MAX) begin
            sum_next = SUM_MAX;
            clipped  = 1'b1;
            n_sum_top++;
         end else if (sum_next < SUM_MIN) begin
            sum_next = SUM_MIN;
            clipped  = 1'b1;
            n_sum_bot++;
         end
         acc = longint'(gain_p_q) * err + longint'(gain_i_q) * sum_next
             + longint'(gain_d_q) * (err - err_last);
         err_sum  = sum_next;
         err_last = err;
         n_pos++;
      end else begin
         // incremental form: sum untouched, history shifts
         acc = longint'(gain_p_q) * err - longint'(gain_i_q) * err_last
             + longint'(gain_d_q) * err_prev;
         err_prev = err_last;
         err_last = err;
         n_inc++;
      end
      // drop fraction bits (floor), then clip to the output width
      scaled = acc >>> FRAC_BITS;
      if (scaled > DRIVE_MAX) begin
         scaled  = DRIVE_MAX;
         clipped = 1'b1;
         n_drive_sat++;
      end else if (scaled < DRIVE_MIN) begin
         scaled  = DRIVE_MIN;
         clipped = 1'b1;
         n_drive_sat++;
      end
      if (clipped)
         n_flagged++;
      r.drive     = scaled[OUT_WIDTH-1:0];
      r.saturated = clipped;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      drive_result_type want;
      if (reset) begin
         setpoint_q = '0;
         gain_p_q   = '0;
         gain_i_q   = '0;
         gain_d_q   = '0;
         form_q     = FORM_POSITIONAL;
         err_last   = 0;
         err_prev   = 0;
         err_sum    = 0;
         drive_q.delete();
      end else begin
         // register writes; bits above a register's width are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SETPOINT:    setpoint_q = csr_data[DATA_WIDTH-1:0];
               CSR_GAIN_P:      gain_p_q   = csr_data[GAIN_WIDTH-1:0];
               CSR_GAIN_I:      gain_i_q   = csr_data[GAIN_WIDTH-1:0];
               CSR_GAIN_D:      gain_d_q   = csr_data[GAIN_WIDTH-1:0];
               CSR_FORM_SELECT: form_q     = csr_data[0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready)
            drive_q.push_back(next_drive(req_tdata[DATA_WIDTH-1:0]));

         // result check against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (drive_q.size() == 0) begin
               report_mismatch($sformatf("result with nothing outstanding, drive %0d",
                                         $signed(rsp_tdata)));
            end else begin
               want = drive_q.pop_front();
               if (rsp_tdata !== want.drive)
                  report_mismatch($sformatf("drive %0d, predicted %0d",
                                            $signed(rsp_tdata), $signed(want.drive)));
               if (rsp_tuser !== want.saturated)
                  report_mismatch($sformatf("saturated flag %b, predicted %b (drive %0d)",
                                            rsp_tuser, want.saturated, $signed(want.drive)));
            end
         end

         if (run_done && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (drive_q.size() != 0)
               report_mismatch($sformatf("%0d predicted results never arrived",
                                         drive_q.size()));
         end
      end
      pending_count <= drive_q.size();
   end

endmodule

// File: tb/tb_pid_controller_inc_pos_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_controller_inc_pos_core
// Stimulus and verdict for the positional / incremental PID core.
// ----------------------------------------------------------------------------
// A short directed part hits the measurement and gain extremes, the widest
// errors and the history difference between the two forms. Random phases
// then run with fresh register settings each, random idling on both sides,
// one long response hold-off and one full drain. A sweep with near-maximal
// errors and the largest integral gain grows the error sum until the drive
// clips. The checker beside the core predicts and compares; this module
// only makes traffic and reports.
// ----------------------------------------------------------------------------
module tb_pid_controller_inc_pos_core;
   import pidc_pkg::*;

   localparam int DATA_WIDTH  = 16;
   localparam int FRAC_BITS   = 8;
   localparam int SUM_WIDTH   = 32;
   localparam int TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int CSR_W       = (DATA_WIDTH > 16) ? DATA_WIDTH : 16;
   localparam int LATENCY     = 5;
   localparam int IDLE_PCT    = 9;
   localparam int HOLD_CYCLES = 48;
   localparam int RUN_LIMIT   = 2_000_000;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [TDATA_WIDTH-1:0]     req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [OUT_WIDTH-1:0]       rsp_tdata;
   logic                       rsp_tuser;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [CSR_W-1:0]           csr_data   = '0;
   logic                       run_done   = 1'b0;

   int pending_count;
   int fail_count;
   int positional_steps;
   int incremental_steps;
   int flagged_steps;
   int drive_clips;
   int sum_top_hits;
   int sum_bottom_hits;

   int cycle_count   = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   bit steady        = 1'b0;

   pid_controller_inc_pos_core #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .SUM_WIDTH  (SUM_WIDTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   pid_drive_checker #(
      .DATA_WIDTH     (DATA_WIDTH),
      .FRAC_BITS      (FRAC_BITS),
      .SUM_WIDTH      (SUM_WIDTH),
      .TDATA_WIDTH    (TDATA_WIDTH),
      .CSR_DATA_WIDTH (CSR_W)
   ) checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .run_done          (run_done),
      .pending_count     (pending_count),
      .fail_count        (fail_count),
      .positional_steps  (positional_steps),
      .incremental_steps (incremental_steps),
      .flagged_steps     (flagged_steps),
      .drive_clips       (drive_clips),
      .sum_top_hits      (sum_top_hits),
      .sum_bottom_hits   (sum_bottom_hits)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // response side: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_served++;
         end else if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one measurement, maybe after a short gap, and wait for acceptance
   task automatic send_item(input logic [DATA_WIDTH-1:0] meas);
      if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         req_tdata  <= TDATA_WIDTH'($urandom);
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_WIDTH'(meas);
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and wait until every predicted result has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // One register write; csr_valid is left high for back-to-back writes
   task automatic csr_put(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [CSR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Full register update while idle, plus a write to an unmapped index
   task automatic program_controller(input logic [CSR_W-1:0] sp, input logic [CSR_W-1:0] gp,
                                     input logic [CSR_W-1:0] gi, input logic [CSR_W-1:0] gd,
                                     input logic form);
      logic [CSR_W-1:0]           form_word;
      logic [CSR_INDEX_WIDTH-1:0] stray_idx;
      form_word    = CSR_W'($urandom);
      form_word[0] = form;
      stray_idx    = CSR_INDEX_WIDTH'($urandom_range(int'(CSR_FORM_SELECT) + 1,
                                                     (1 << CSR_INDEX_WIDTH) - 1));
      settle();
      csr_put(CSR_SETPOINT, sp);
      csr_put(CSR_GAIN_P, gp);
      csr_put(CSR_GAIN_I, gi);
      csr_put(CSR_GAIN_D, gd);
      csr_put(CSR_FORM_SELECT, form_word);
      csr_put(stray_idx, CSR_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Register value with a bias toward the signed extremes and zero
   function automatic logic [CSR_W-1:0] rand_setting();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return CSR_W'($urandom);
      endcase
   endfunction

   function automatic logic [DATA_WIDTH-1:0] rand_meas();
      case ($urandom_range(0, 19))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'hFFFF;
         3:       return 16'h0000;
         default: return DATA_WIDTH'($urandom);
      endcase
   endfunction

   // Random settings, random measurements; optionally with back-pressure
   task automatic random_phase(input int count, input bit calm, input bit press);
      program_controller(rand_setting(), rand_setting(), rand_setting(), rand_setting(),
                         logic'($urandom_range(0, 1)));
      steady = calm;
      for (int i = 0; i < count; i++) begin
         if (press && i == count / 3)
            hold_requests++;
         if (press && i == (2 * count) / 3)
            settle();
         send_item(rand_meas());
      end
      steady = 1'b0;
   endtask

   // Grow the error sum with near-maximal errors and the largest integral gain
   task automatic sum_sweep(input bit up, input int chunks, input int per_chunk);
      logic [DATA_WIDTH-1:0] meas;
      for (int c = 0; c < chunks; c++) begin
         program_controller(up ? 16'h7FFF : 16'h8000, rand_setting(), 16'h7FFF,
                            rand_setting(), FORM_POSITIONAL);
         for (int i = 0; i < per_chunk; i++) begin
            meas = up ? 16'h8000 + DATA_WIDTH'($urandom_range(0, 63))
                      : 16'h7FFF - DATA_WIDTH'($urandom_range(0, 63));
            send_item(meas);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes of the measurement, alternating bit patterns
      program_controller(16'h0000, 16'h0100, 16'h0010, 16'h0080, FORM_POSITIONAL);
      send_item(16'h8000);
      send_item(16'h7FFF);
      send_item(16'h0000);
      send_item(16'hFFFF);
      send_item(16'h0001);
      send_item(16'h5555);
      send_item(16'hAAAA);

      // widest positive error, extreme gains, positional
      program_controller(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, FORM_POSITIONAL);
      send_item(16'h8000);
      send_item(16'h8000);
      send_item(16'h7FFF);

      // widest negative error, extreme gains, incremental
      program_controller(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, FORM_INCREMENTAL);
      send_item(16'h7FFF);
      send_item(16'h7FFF);
      send_item(16'h8000);
      send_item(16'h0000);

      // positional steps leave the older error untouched between incremental runs
      program_controller(16'h0100, 16'h0100, 16'h0100, 16'h0100, FORM_INCREMENTAL);
      send_item(16'h0010);
      send_item(16'h0020);
      program_controller(16'h0100, 16'h0100, 16'h0100, 16'h0100, FORM_POSITIONAL);
      send_item(16'h0030);
      send_item(16'h0040);
      program_controller(16'h0100, 16'h0100, 16'h0100, 16'h0100, FORM_INCREMENTAL);
      send_item(16'h0050);
      send_item(16'h0060);

      // random traffic; one phase without idling, one with back-pressure and a drain
      random_phase(100, 1'b0, 1'b0);
      random_phase(100, 1'b1, 1'b0);
      random_phase(100, 1'b0, 1'b1);
      random_phase(60, 1'b0, 1'b0);
      random_phase(60, 1'b0, 1'b0);

      // large error sum until the drive saturates
      sum_sweep(1'b1, 2, 140);

      random_phase(20, 1'b0, 1'b0);
      random_phase(20, 1'b0, 1'b0);

      settle();
      repeat (LATENCY * 4) @(posedge clock);
      run_done <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Checked %0d drive values: %0d positional, %0d incremental, %0d flagged.",
               positional_steps + incremental_steps, positional_steps, incremental_steps,
               flagged_steps);
      $display("Drive clipped %0d times; error sum hit its top bound %0d, bottom bound %0d.",
               drive_clips, sum_top_hits, sum_bottom_hits);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: pid_controller_inc_pos_core.f
hdl/pidc_pkg.sv
hdl/pidc_error.sv
hdl/pidc_mac.sv
hdl/pid_controller_inc_pos_core.sv
hdl/pidc_checker.sv
tb/pid_drive_checker.sv
tb/tb_pid_controller_inc_pos_core.sv
